### sv/assert_macros.svh
// Assertion macros used by the RTL top level.
// No dependencies; the macros expand to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### sv/mqrf_pkg.sv
// Shared types and constants for the multi-queue ring FIFO.
// No dependencies.
`default_nettype none
package mqrf_pkg;

  localparam int CMD_W     = 3;
  localparam int QID_W     = 3;
  localparam int DATA_W    = 32;
  localparam int CAP_W     = 5;
  localparam int CNT_OUT_W = 5;
  localparam int NUM_REGS  = 4;
  localparam int CFG_IDX_W = 2;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 3'd0,
    CMD_GET    = 3'd1,
    CMD_VIEW   = 3'd2,
    CMD_DELETE = 3'd3,
    CMD_COUNT  = 3'd4
  } cmd_t;

endpackage
`default_nettype wire

### sv/multi_queue_ring_fifo.sv
// Top level of the multi-queue ring FIFO: command decode, queue pointers and the shared store.
// Depends on mqrf_pkg and assert_macros.svh.
//
// NUM_QUEUES circular queues share one store of NUM_QUEUES*QUEUE_DEPTH items; queue q
// owns entries q*QUEUE_DEPTH and up. Each transfer on the input channel carries one
// command (add, get, view, delete, count) and gives exactly one result, valid from the
// next cycle and held until it is transferred. A command is taken in every cycle in which
// the result register is empty or its result is transferred: the decision, the pointer
// update and the single store access (one write port, one registered read port) all
// happen at the edge that takes the command, so a stalled result stalls the input.
// Writing capacity register i sets queue i's capacity and empties it; write
// configuration only while no command is in flight.
`default_nettype none
module multi_queue_ring_fifo #(
  parameter int NUM_QUEUES  = 4,
  parameter int QUEUE_DEPTH = 16,
  parameter int ITEM_WIDTH  = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_write_en,
  input  wire logic [mqrf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [mqrf_pkg::CAP_W-1:0]     cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [mqrf_pkg::CMD_W-1:0]     command,
  input  wire logic [mqrf_pkg::QID_W-1:0]     queue_id,
  input  wire logic [mqrf_pkg::DATA_W-1:0]    write_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                ok,
  output logic [mqrf_pkg::DATA_W-1:0]         read_data,
  output logic [mqrf_pkg::CNT_OUT_W-1:0]      item_count
);

  localparam int PtrW   = $clog2(QUEUE_DEPTH);
  localparam int CntW   = $clog2(QUEUE_DEPTH + 1);
  localparam int CmpW   = (CntW > mqrf_pkg::CAP_W) ? CntW : mqrf_pkg::CAP_W;
  localparam int CntXW  = (CntW > mqrf_pkg::CNT_OUT_W) ? CntW : mqrf_pkg::CNT_OUT_W;
  localparam int QIdxW  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int Depth  = NUM_QUEUES * QUEUE_DEPTH;
  localparam int AddrW  = $clog2(Depth);
  localparam int ExtW   = (ITEM_WIDTH > mqrf_pkg::DATA_W) ? ITEM_WIDTH : mqrf_pkg::DATA_W;

  logic [mqrf_pkg::CAP_W-1:0] cap [mqrf_pkg::NUM_REGS];
  logic [PtrW-1:0]            head [NUM_QUEUES];
  logic [PtrW-1:0]            tail [NUM_QUEUES];
  logic [CntW-1:0]            fill [NUM_QUEUES];
  logic [ITEM_WIDTH-1:0]      mem [Depth];
  logic [ITEM_WIDTH-1:0]      mem_rdata;

  logic                 rd_sel;
  logic [CntW-1:0]      cnt;

  logic                 in_fire;
  logic                 qv;
  logic [QIdxW-1:0]     qi;
  mqrf_pkg::cmd_t       cmd;
  logic [CmpW-1:0]      cap_raw;
  logic [CmpW-1:0]      cap_eff;
  logic [PtrW-1:0]      head_sel;
  logic [PtrW-1:0]      tail_sel;
  logic [CntW-1:0]      fill_sel;
  logic                 is_pop_cmd;
  logic                 push_ok;
  logic                 pop_ok;
  logic                 adv_head;
  logic                 rd_sel_next;
  logic                 ok_next;
  logic [CmpW-1:0]      tail_inc;
  logic [CmpW-1:0]      head_inc;
  logic [PtrW-1:0]      tail_adv;
  logic [PtrW-1:0]      head_adv;
  logic [CntW-1:0]      fill_after;
  logic [CntW-1:0]      cnt_next;
  logic [AddrW-1:0]     waddr;
  logic [AddrW-1:0]     raddr;
  logic [ExtW-1:0]      wd_ext;
  logic [ExtW-1:0]      rd_ext;
  logic [CntXW-1:0]     cnt_ext;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    qv  = (4'(queue_id) < 4'(NUM_QUEUES));
    qi  = qv ? queue_id[QIdxW-1:0] : '0;
    cmd = mqrf_pkg::cmd_t'(command);
    if (4'(qi) < 4'(mqrf_pkg::NUM_REGS)) begin
      cap_raw = CmpW'(cap[mqrf_pkg::CFG_IDX_W'(qi)]);
    end else begin
      cap_raw = CmpW'(QUEUE_DEPTH);
    end
    cap_eff  = (cap_raw > CmpW'(QUEUE_DEPTH)) ? CmpW'(QUEUE_DEPTH) : cap_raw;
    head_sel = head[qi];
    tail_sel = tail[qi];
    fill_sel = fill[qi];

    is_pop_cmd = 1'b0;
    case (cmd)
      mqrf_pkg::CMD_GET, mqrf_pkg::CMD_VIEW, mqrf_pkg::CMD_DELETE: is_pop_cmd = 1'b1;
      default: is_pop_cmd = 1'b0;
    endcase

    push_ok     = qv && (cmd == mqrf_pkg::CMD_ADD) && (CmpW'(fill_sel) < cap_eff);
    pop_ok      = qv && is_pop_cmd && (fill_sel != '0);
    adv_head    = pop_ok && (cmd != mqrf_pkg::CMD_VIEW);
    rd_sel_next = pop_ok && (cmd != mqrf_pkg::CMD_DELETE);
    ok_next     = push_ok || pop_ok || (qv && (cmd == mqrf_pkg::CMD_COUNT));

    tail_inc = CmpW'(tail_sel) + CmpW'(1);
    head_inc = CmpW'(head_sel) + CmpW'(1);
    tail_adv = (tail_inc >= cap_eff) ? '0 : tail_inc[PtrW-1:0];
    head_adv = (head_inc >= cap_eff) ? '0 : head_inc[PtrW-1:0];

    if (push_ok) begin
      fill_after = fill_sel + CntW'(1);
    end else if (adv_head) begin
      fill_after = fill_sel - CntW'(1);
    end else begin
      fill_after = fill_sel;
    end
    cnt_next = qv ? fill_after : '0;

    waddr  = AddrW'(qi) * AddrW'(QUEUE_DEPTH) + AddrW'(tail_sel);
    raddr  = AddrW'(qi) * AddrW'(QUEUE_DEPTH) + AddrW'(head_sel);
    wd_ext = ExtW'(write_data);
  end

  // Store: at most one write or one registered read per transfer.
  always_ff @(posedge clk) begin
    if (in_fire && push_ok) begin
      mem[waddr] <= wd_ext[ITEM_WIDTH-1:0];
    end
    if (in_fire && rd_sel_next) begin
      mem_rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < mqrf_pkg::NUM_REGS; i++) begin
        cap[i] <= mqrf_pkg::CAP_RESET;
      end
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head[i] <= '0;
        tail[i] <= '0;
        fill[i] <= '0;
      end
      out_valid <= 1'b0;
    end else begin
      if (cfg_write_en && (32'(cfg_index) < 32'(NUM_QUEUES))) begin
        cap[cfg_index]        <= cfg_data;
        head[QIdxW'(cfg_index)] <= '0;
        tail[QIdxW'(cfg_index)] <= '0;
        fill[QIdxW'(cfg_index)] <= '0;
      end else if (in_fire) begin
        if (push_ok) begin
          tail[qi] <= tail_adv;
        end
        if (adv_head) begin
          head[qi] <= head_adv;
        end
        if (qv) begin
          fill[qi] <= fill_after;
        end
      end
      if (in_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result register: hold until transferred.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      ok     <= ok_next;
      rd_sel <= rd_sel_next;
      cnt    <= cnt_next;
    end
  end

  assign rd_ext     = ExtW'(mem_rdata);
  assign read_data  = rd_sel ? rd_ext[mqrf_pkg::DATA_W-1:0] : '0;
  assign cnt_ext    = CntXW'(cnt);
  assign item_count = cnt_ext[mqrf_pkg::CNT_OUT_W-1:0];

`include "assert_macros.svh"

  `ASSERT_IMPLIES(a_fail_no_data, clk, rst, out_valid && !ok, read_data == '0)
  `ASSERT_NEXT(a_bad_id_result, clk, rst, in_fire && !qv, !ok && (item_count == '0))
  `ASSERT_IMPLIES(a_read_only_on_pop, clk, rst, rd_sel_next, fill_sel != '0)

  for (genvar gq = 0; gq < NUM_QUEUES; gq++) begin : g_fill_chk
    `ASSERT_IMPLIES(a_fill_bound, clk, rst, 1'b1, fill[gq] <= CntW'(QUEUE_DEPTH))
  end

endmodule
`default_nettype wire

### dv/tb.sv
`timescale 1ns / 100ps
// Testbench for multi_queue_ring_fifo: directed and random command streams, checked by a
// queue-level predictor. Depends on mqrf_pkg and the RTL top level.
module tb;

  localparam int NQ          = 4;
  localparam int DEPTH       = 16;
  localparam int STALL_LIMIT = 1000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 240;
  localparam logic [mqrf_pkg::CMD_W-1:0] CMD_UNDEF_LO =
      mqrf_pkg::CMD_W'(int'(mqrf_pkg::CMD_COUNT) + 1);
  localparam logic [mqrf_pkg::CMD_W-1:0] CMD_UNDEF_HI = '1;
  localparam logic [mqrf_pkg::QID_W-1:0] QID_BAD_LO   = mqrf_pkg::QID_W'(NQ);
  localparam logic [mqrf_pkg::QID_W-1:0] QID_BAD_HI   = '1;

  typedef struct packed {
    logic [mqrf_pkg::CMD_W-1:0]  cmd;
    logic [mqrf_pkg::QID_W-1:0]  qid;
    logic [mqrf_pkg::DATA_W-1:0] data;
  } queue_cmd_t;

  typedef struct packed {
    logic                           ok;
    logic [mqrf_pkg::DATA_W-1:0]    read_data;
    logic [mqrf_pkg::CNT_OUT_W-1:0] item_count;
  } queue_reply_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_write_en = 1'b0;
  logic [mqrf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [mqrf_pkg::CAP_W-1:0]     cfg_data = '0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [mqrf_pkg::CMD_W-1:0]     command = '0;
  logic [mqrf_pkg::QID_W-1:0]     queue_id = '0;
  logic [mqrf_pkg::DATA_W-1:0]    write_data = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic                           ok;
  logic [mqrf_pkg::DATA_W-1:0]    read_data;
  logic [mqrf_pkg::CNT_OUT_W-1:0] item_count;

  multi_queue_ring_fifo #(
    .NUM_QUEUES (NQ),
    .QUEUE_DEPTH(DEPTH),
    .ITEM_WIDTH (mqrf_pkg::DATA_W)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write_en(cfg_write_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .command     (command),
    .queue_id    (queue_id),
    .write_data  (write_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .ok          (ok),
    .read_data   (read_data),
    .item_count  (item_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  queue_cmd_t   cmd_stream[$];
  queue_reply_t replies_due[$];
  int           drive_idx = 0;
  logic         in_taken = 1'b0;
  logic         steady_phase = 1'b0;
  logic         drain_hold = 1'b0;
  int           stall_cycles = 0;
  logic [mqrf_pkg::CAP_W-1:0] cap_plan[mqrf_pkg::NUM_REGS];

  logic [mqrf_pkg::DATA_W-1:0]    item_mem[NQ*DEPTH];
  logic [3:0]                     head_pos[NQ];
  logic [3:0]                     tail_pos[NQ];
  logic [mqrf_pkg::CNT_OUT_W-1:0] fill_level[NQ];
  logic [mqrf_pkg::CAP_W-1:0]     cap_reg[NQ];

  int errors = 0;
  int n_checked = 0;
  int n_pushes = 0;
  int n_full_rejects = 0;
  int n_empty_rejects = 0;
  int n_bad_ids = 0;
  int n_cap_writes = 0;

  function automatic queue_cmd_t cmd_item(input logic [mqrf_pkg::CMD_W-1:0] cmd,
                                          input logic [mqrf_pkg::QID_W-1:0] qid,
                                          input logic [mqrf_pkg::DATA_W-1:0] data);
    queue_cmd_t c;
    c.cmd  = cmd;
    c.qid  = qid;
    c.data = data;
    return c;
  endfunction

  function automatic queue_cmd_t random_cmd(input int add_weight);
    queue_cmd_t c;
    int r;
    c.qid = ($urandom_range(99) < 8)
            ? mqrf_pkg::QID_W'($urandom_range(QID_BAD_LO, QID_BAD_HI))
            : mqrf_pkg::QID_W'($urandom_range(NQ - 1));
    if ($urandom_range(99) < add_weight) begin
      c.cmd = mqrf_pkg::CMD_ADD;
    end else begin
      r = $urandom_range(99);
      if (r < 35)      c.cmd = mqrf_pkg::CMD_GET;
      else if (r < 55) c.cmd = mqrf_pkg::CMD_VIEW;
      else if (r < 75) c.cmd = mqrf_pkg::CMD_DELETE;
      else if (r < 93) c.cmd = mqrf_pkg::CMD_COUNT;
      else             c.cmd = mqrf_pkg::CMD_W'($urandom_range(CMD_UNDEF_LO, CMD_UNDEF_HI));
    end
    case ($urandom_range(15))
      0:       c.data = '0;
      1:       c.data = '1;
      default: c.data = $urandom;
    endcase
    return c;
  endfunction

  function automatic logic [mqrf_pkg::CAP_W-1:0] pick_capacity();
    case ($urandom_range(7))
      0:       return '0;
      1:       return mqrf_pkg::CAP_W'(1);
      2:       return mqrf_pkg::CAP_W'(2);
      3:       return mqrf_pkg::CAP_W'(DEPTH - 1);
      4:       return mqrf_pkg::CAP_W'(DEPTH);
      5:       return mqrf_pkg::CAP_W'(DEPTH + 1);
      6:       return '1;
      default: return mqrf_pkg::CAP_W'($urandom_range(31));
    endcase
  endfunction

  task automatic reset_queues();
    for (int q = 0; q < NQ; q++) begin
      head_pos[q]   = '0;
      tail_pos[q]   = '0;
      fill_level[q] = '0;
      cap_reg[q]    = mqrf_pkg::CAP_RESET;
    end
  endtask

  task automatic predict_queue_op(input queue_cmd_t c);
    queue_reply_t r;
    int q;
    int lim;
    int base;
    r = '0;
    q = c.qid;
    if (q < NQ) begin
      lim  = (cap_reg[q] > DEPTH) ? DEPTH : cap_reg[q];
      base = q * DEPTH;
      case (c.cmd)
        mqrf_pkg::CMD_ADD: begin
          if (fill_level[q] < lim) begin
            item_mem[base + tail_pos[q]] = c.data;
            tail_pos[q] = (tail_pos[q] + 1 >= lim) ? '0 : tail_pos[q] + 1'b1;
            fill_level[q]++;
            r.ok = 1'b1;
            n_pushes++;
          end else begin
            n_full_rejects++;
          end
        end
        mqrf_pkg::CMD_GET, mqrf_pkg::CMD_VIEW, mqrf_pkg::CMD_DELETE: begin
          if (fill_level[q] != 0) begin
            if (c.cmd != mqrf_pkg::CMD_DELETE) r.read_data = item_mem[base + head_pos[q]];
            if (c.cmd != mqrf_pkg::CMD_VIEW) begin
              head_pos[q] = (head_pos[q] + 1 >= lim) ? '0 : head_pos[q] + 1'b1;
              fill_level[q]--;
            end
            r.ok = 1'b1;
          end else begin
            n_empty_rejects++;
          end
        end
        mqrf_pkg::CMD_COUNT: r.ok = 1'b1;
        default: ;
      endcase
      r.item_count = fill_level[q];
    end else begin
      n_bad_ids++;
    end
    replies_due.push_back(r);
  endtask

  task automatic check_reply();
    queue_reply_t want;
    if (replies_due.size() == 0) begin
      errors++;
      if (errors <= 40)
        $display("%0t: unexpected reply ok=%0b read_data=%h item_count=%0d",
                 $time, ok, read_data, item_count);
    end else begin
      want = replies_due.pop_front();
      n_checked++;
      if (ok !== want.ok || read_data !== want.read_data ||
          item_count !== want.item_count) begin
        errors++;
        if (errors <= 40)
          $display({"%0t: reply mismatch: expected ok=%0b read_data=%h item_count=%0d,",
                    " got ok=%0b read_data=%h item_count=%0d"},
                   $time, want.ok, want.read_data, want.item_count,
                   ok, read_data, item_count);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      reset_queues();
      replies_due.delete();
      in_taken     <= 1'b0;
      stall_cycles <= 0;
    end else begin
      if (cfg_write_en && cfg_index < NQ) begin
        cap_reg[cfg_index]    = cfg_data;
        head_pos[cfg_index]   = '0;
        tail_pos[cfg_index]   = '0;
        fill_level[cfg_index] = '0;
        n_cap_writes++;
      end
      if (out_valid && out_ready) check_reply();
      if (in_valid && in_ready) predict_queue_op(cmd_item(command, queue_id, write_data));
      in_taken <= in_valid && in_ready;
      if ((in_valid && in_ready) || (out_valid && out_ready) ||
          !(drive_idx != cmd_stream.size() || in_valid || replies_due.size() != 0))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (drain_hold && replies_due.size() != 0) begin
        in_valid <= 1'b0;
      end else if (drive_idx == cmd_stream.size() ||
                   (!steady_phase && $urandom_range(99) < 10)) begin
        in_valid   <= 1'b0;
        drain_hold = 1'b0;
      end else if (!steady_phase && $urandom_range(199) == 0) begin
        in_valid   <= 1'b0;
        drain_hold = 1'b1;
      end else begin
        drain_hold = 1'b0;
        in_valid   <= 1'b1;
        command    <= cmd_stream[drive_idx].cmd;
        queue_id   <= cmd_stream[drive_idx].qid;
        write_data <= cmd_stream[drive_idx].data;
        drive_idx  <= drive_idx + 1;
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= !rst && (steady_phase || $urandom_range(99) >= 10);
  end

  task automatic program_capacities(input logic [mqrf_pkg::NUM_REGS-1:0] write_mask);
    for (int i = 0; i < mqrf_pkg::NUM_REGS; i++) begin
      if (write_mask[i]) begin
        @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= mqrf_pkg::CFG_IDX_W'(i);
        cfg_data     <= cap_plan[i];
      end
    end
    @(negedge clk);
    cfg_write_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    do
      @(negedge clk);
    while (drive_idx != cmd_stream.size() || in_valid || replies_due.size() != 0);
  endtask

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
    $display("[multi_queue_ring_fifo] ERROR");
    $finish;
  end

  initial begin
    int add_weight;
    logic [mqrf_pkg::NUM_REGS-1:0] mask;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    cap_plan[0] = mqrf_pkg::CAP_W'(DEPTH);
    cap_plan[1] = mqrf_pkg::CAP_W'(1);
    cap_plan[2] = '0;
    cap_plan[3] = '1;
    program_capacities('1);

    cmd_stream.push_back(cmd_item(mqrf_pkg::CMD_COUNT,  3'd0, '0));
    cmd_stream.push_back(cmd_item(mqrf_pkg::CMD_GET,    3'd0, '0));
    cmd_stream.push_back(cmd_item(mqrf_pkg::CMD_VIEW,   3'd0, '1));
    cmd_stream.push_back(cmd_item(mqrf_pkg::CMD_DELETE, 3'd0, '0));
    cmd_stream.push_back(cmd_item(mqrf_pkg::CMD_ADD,    3'd0, '0));
    cmd_stream.push_back(cmd_item(mqrf_pkg::CMD_ADD,    3'd0, '1));
    cmd_stream.push_back(cmd_item(mqrf_pkg::CMD_VIEW,   3'd0, '0));
    cmd_stream.push_back(cmd_item(mqrf_pkg::CMD_GET,    3'd0, '0));
    cmd_stream.push_back(cmd_item(mqrf_pkg::CMD_GET,    3'd0, '0));
    cmd_stream.push_back(cmd_item(mqrf_pkg::CMD_ADD,    3'd1, 32'h1234_5678));
    cmd_stream.push_back(cmd_item(mqrf_pkg::CMD_ADD,    3'd1, 32'hDEAD_BEEF));
    cmd_stream.push_back(cmd_item(mqrf_pkg::CMD_GET,    3'd1, '0));
    cmd_stream.push_back(cmd_item(mqrf_pkg::CMD_ADD,    3'd1, 32'h9ABC_DEF0));
    cmd_stream.push_back(cmd_item(mqrf_pkg::CMD_DELETE, 3'd1, '0));
    cmd_stream.push_back(cmd_item(mqrf_pkg::CMD_ADD,    3'd2, 32'h5555_AAAA));
    cmd_stream.push_back(cmd_item(mqrf_pkg::CMD_COUNT,  3'd2, '0));
    cmd_stream.push_back(cmd_item(mqrf_pkg::CMD_ADD,    3'd3, 32'hA5A5_A5A5));
    cmd_stream.push_back(cmd_item(mqrf_pkg::CMD_VIEW,   3'd3, '0));
    cmd_stream.push_back(cmd_item(mqrf_pkg::CMD_ADD,    QID_BAD_LO, '1));
    cmd_stream.push_back(cmd_item(mqrf_pkg::CMD_COUNT,  QID_BAD_HI, '0));
    cmd_stream.push_back(cmd_item(mqrf_pkg::CMD_GET,    QID_BAD_LO + 1'b1, '0));
    cmd_stream.push_back(cmd_item(CMD_UNDEF_LO, 3'd3, 32'h0F0F_0F0F));
    cmd_stream.push_back(cmd_item(CMD_UNDEF_HI, 3'd0, 32'hF0F0_F0F0));
    cmd_stream.push_back(cmd_item(CMD_UNDEF_LO + 1'b1, QID_BAD_HI - 1'b1, '1));
    cmd_stream.push_back(cmd_item(mqrf_pkg::CMD_COUNT,  3'd3, '0));
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      repeat (3) @(negedge clk);
      steady_phase <= (p == 3);
      for (int i = 0; i < mqrf_pkg::NUM_REGS; i++) cap_plan[i] = pick_capacity();
      mask = (p == 0) ? '1
                      : mqrf_pkg::NUM_REGS'($urandom_range(1, (1 << mqrf_pkg::NUM_REGS) - 1));
      program_capacities(mask);
      add_weight = $urandom_range(30, 60);
      for (int n = 0; n < PHASE_ITEMS; n++) cmd_stream.push_back(random_cmd(add_weight));
      wait_drained();
    end

    repeat (8) @(negedge clk);
    $display("Checked %0d replies over %0d capacity writes: %0d pushes,",
             n_checked, n_cap_writes, n_pushes);
    $display("%0d full and %0d empty rejects, %0d commands to bad queue ids, %0d failures",
             n_full_rejects, n_empty_rejects, n_bad_ids, errors);
    if (errors == 0) begin
      $display("[multi_queue_ring_fifo] OK");
    end else begin
      $display("[multi_queue_ring_fifo] ERROR");
    end
    $finish;
  end

endmodule
